>>> rtl/dhst_pkg.sv
// Package for the double hash symbol table: transaction codes and field widths.
// Used by the top level, the assertion checker and the testbench files; depends on nothing.
package dhst_pkg;

   // Field widths fixed by the interface.
   localparam int KIND_W   = 2;
   localparam int CHAR_W   = 7;
   localparam int TYPE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 8;
   localparam int CSR_W    = 9;
   localparam int HASH_W   = 64;

   // Reset value of the table size register.
   localparam logic [CSR_W-1:0] SIZE_RESET = 9'd251;
   localparam int SIZE_MIN = 5;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

endpackage

>>> rtl/double_hash_symbol_table.sv
// Top level of the double hash symbol table: hashing, remainder unit, probe sequencer
// and the slot memories. Depends on dhst_pkg.
//
// Characters are taken one per cycle while busy is low; each one updates the 64-bit
// hash, and the first 49 of a name are kept in the name buffer. On the last
// character of a name shorter than 50 busy rises and the block works alone. A name
// end passes through the bit-serial remainder unit that forms both hash remainders,
// then makes a status read and a length check for each occupied slot probed, plus a
// read and a compare per compared character, and a status read for the empty slot
// that ends a search. An insert adds a read and a write per character copied into
// the character memory. A clear, a too-long name and a non-final character need no
// probing. Each result shows for exactly one cycle on rsp_valid; the receiver cannot
// stall it, and the next transaction may start in that same cycle.
module double_hash_symbol_table #(
   parameter int TABLE_DEPTH = 256,
   parameter int NAME_BYTES  = 50
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dhst_pkg::KIND_W-1:0]    req_kind,
   input  logic [dhst_pkg::CHAR_W-1:0]    req_name_char,
   input  logic                           req_last_char,
   input  logic [dhst_pkg::TYPE_W-1:0]    req_var_type,
   output logic                           rsp_valid,
   output logic [dhst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [dhst_pkg::INDEX_W-1:0]   rsp_slot_index,
   output logic [dhst_pkg::TYPE_W-1:0]    rsp_found_type,
   input  logic                           csr_write_en,
   input  logic [dhst_pkg::CSR_W-1:0]     csr_write_data
);

   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam int SW     = $clog2(TABLE_DEPTH + 1);
   localparam int NI_W   = $clog2(NAME_BYTES);
   localparam int NL_W   = $clog2(NAME_BYTES + 1);
   localparam int CA_W   = $clog2(TABLE_DEPTH * NAME_BYTES);
   localparam int DC_W   = $clog2(dhst_pkg::HASH_W);
   localparam int META_W = dhst_pkg::TYPE_W + NL_W;

   localparam logic [NL_W-1:0] NAME_MAX  = NL_W'(NAME_BYTES);
   localparam logic [NL_W-1:0] BUF_LIMIT = NL_W'(NAME_BYTES - 1);

   // Sequencer state codes.
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DIV     = 3'd1;
   localparam logic [2:0] S_PROBE   = 3'd2;
   localparam logic [2:0] S_META    = 3'd3;
   localparam logic [2:0] S_CMP_RD  = 3'd4;
   localparam logic [2:0] S_CMP     = 3'd5;
   localparam logic [2:0] S_COPY_RD = 3'd6;
   localparam logic [2:0] S_COPY_WR = 3'd7;

   // Registers.
   logic [2:0]                   state_ff, state_in;
   logic [dhst_pkg::CSR_W-1:0]   csr_ff;
   logic [dhst_pkg::HASH_W-1:0]  hash_ff, hash_in;
   logic [NL_W-1:0]              len_ff, len_in;
   logic [NL_W-1:0]              op_len_ff, op_len_in;
   logic [dhst_pkg::KIND_W-1:0]  op_kind_ff, op_kind_in;
   logic [dhst_pkg::TYPE_W-1:0]  op_type_ff, op_type_in;
   logic [SW-1:0]                size_ff, size_in;
   logic [dhst_pkg::HASH_W-1:0]  key_ff, key_in;
   logic [DC_W-1:0]              dcnt_ff, dcnt_in;
   logic [SW-1:0]                rem1_ff, rem1_in;
   logic [SW-1:0]                rem2_ff, rem2_in;
   logic [SW-1:0]                slot_ff, slot_in;
   logic [SW-1:0]                pcnt_ff, pcnt_in;
   logic [NI_W-1:0]              j_ff, j_in;
   logic [CA_W-1:0]              base_ff, base_in;
   logic [TABLE_DEPTH-1:0]       valid_ff, valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dhst_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [dhst_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [dhst_pkg::TYPE_W-1:0]  rsp_type_ff, rsp_type_in;

   // Memories and their registered read data.
   logic [dhst_pkg::CHAR_W-1:0]  nb_mem [NAME_BYTES];
   logic [META_W-1:0]            meta_mem [TABLE_DEPTH];
   logic [dhst_pkg::CHAR_W-1:0]  chr_mem [TABLE_DEPTH * NAME_BYTES];
   logic [dhst_pkg::CHAR_W-1:0]  nb_rd_ff;
   logic [META_W-1:0]            meta_rd_ff;
   logic [dhst_pkg::CHAR_W-1:0]  chr_rd_ff;

   // Memory port controls.
   logic                         nb_we;
   logic [NI_W-1:0]              nb_waddr;
   logic                         meta_we;
   logic                         chr_we;
   logic [CA_W-1:0]              chr_addr;

   // Helpers.
   logic                         accept;
   logic [SLOT_W-1:0]            slot_idx;
   logic [SW-1:0]                size_clamped;
   logic [SW:0]                  r1_sh, r2_sh, step_sum;
   logic [SW-1:0]                div2;
   logic [SW-1:0]                step;
   logic [NL_W-1:0]              meta_len;
   logic [dhst_pkg::TYPE_W-1:0]  meta_type;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign slot_idx  = slot_ff[SLOT_W-1:0];
   assign meta_len  = meta_rd_ff[NL_W-1:0];
   assign meta_type = meta_rd_ff[META_W-1:NL_W];
   assign chr_addr  = base_ff + CA_W'(j_ff);
   assign nb_waddr  = len_ff[NI_W-1:0];
   assign nb_we     = accept && (req_kind == dhst_pkg::KIND_INSERT ||
                      req_kind == dhst_pkg::KIND_LOOKUP) && (len_ff < BUF_LIMIT);

   // Table size register clamped into the usable range.
   always_comb begin
      int unsigned s;
      s = 32'(csr_ff);
      if (s < dhst_pkg::SIZE_MIN) s = dhst_pkg::SIZE_MIN;
      if (s > TABLE_DEPTH) s = TABLE_DEPTH;
      size_clamped = SW'(s);
   end

   // One restoring step of both remainders per cycle.
   assign div2  = size_ff - SW'(3);
   assign r1_sh = {rem1_ff, key_ff[dhst_pkg::HASH_W-1]};
   assign r2_sh = {rem2_ff, key_ff[dhst_pkg::HASH_W-1]};

   // Probe stride and the next probe position, reduced by one subtract.
   assign step     = rem2_ff + SW'(1);
   assign step_sum = {1'b0, slot_ff} + {1'b0, step};

   // Sequencer.
   always_comb begin
      logic last_probe;
      state_in      = state_ff;
      hash_in       = hash_ff;
      len_in        = len_ff;
      op_len_in     = op_len_ff;
      op_kind_in    = op_kind_ff;
      op_type_in    = op_type_ff;
      size_in       = size_ff;
      key_in        = key_ff;
      dcnt_in       = dcnt_ff;
      rem1_in       = rem1_ff;
      rem2_in       = rem2_ff;
      slot_in       = slot_ff;
      pcnt_in       = pcnt_ff;
      j_in          = j_ff;
      base_in       = base_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = '0;
      rsp_type_in   = '0;
      meta_we       = 1'b0;
      chr_we        = 1'b0;
      last_probe    = (pcnt_ff + SW'(1) == size_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == dhst_pkg::KIND_CLEAR) begin
                  valid_in      = '0;
                  hash_in       = '0;
                  len_in        = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dhst_pkg::ST_CLEARED;
               end else if (req_kind == dhst_pkg::KIND_INSERT ||
                            req_kind == dhst_pkg::KIND_LOOKUP) begin
                  hash_in = (hash_ff << 5) - hash_ff +
                            dhst_pkg::HASH_W'(req_name_char);
                  if (len_ff < NAME_MAX) len_in = len_ff + NL_W'(1);
                  if (req_last_char) begin
                     hash_in = '0;
                     len_in  = '0;
                     if (len_ff + NL_W'(1) >= NAME_MAX) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = dhst_pkg::ST_TOO_LONG;
                     end else begin
                        key_in     = (hash_ff << 5) - hash_ff +
                                     dhst_pkg::HASH_W'(req_name_char);
                        op_len_in  = len_ff + NL_W'(1);
                        op_kind_in = req_kind;
                        op_type_in = req_var_type;
                        size_in    = size_clamped;
                        rem1_in    = '0;
                        rem2_in    = '0;
                        dcnt_in    = '0;
                        state_in   = S_DIV;
                     end
                  end
               end
            end
         end

         S_DIV: begin
            rem1_in = (r1_sh >= {1'b0, size_ff}) ? SW'(r1_sh - {1'b0, size_ff})
                                                 : SW'(r1_sh);
            rem2_in = (r2_sh >= {1'b0, div2}) ? SW'(r2_sh - {1'b0, div2})
                                              : SW'(r2_sh);
            key_in  = key_ff << 1;
            dcnt_in = dcnt_ff + DC_W'(1);
            if (dcnt_ff == DC_W'(dhst_pkg::HASH_W - 1)) begin
               slot_in  = rem1_in;
               pcnt_in  = '0;
               state_in = S_PROBE;
            end
         end

         // Slot status read is issued here; an empty slot ends the search.
         S_PROBE: begin
            base_in = CA_W'(slot_idx) * CA_W'(NAME_BYTES);
            if (!valid_ff[slot_idx]) begin
               if (op_kind_ff == dhst_pkg::KIND_INSERT) begin
                  valid_in[slot_idx] = 1'b1;
                  meta_we            = 1'b1;
                  rsp_status_in      = dhst_pkg::ST_INSERTED;
                  j_in               = '0;
                  state_in           = S_COPY_RD;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dhst_pkg::ST_NOT_FOUND;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_META;
            end
         end

         // Stored length against this name's length.
         S_META: begin
            j_in = '0;
            if (meta_len != op_len_ff) begin
               if (last_probe) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (op_kind_ff == dhst_pkg::KIND_INSERT) ?
                                  dhst_pkg::ST_FULL : dhst_pkg::ST_NOT_FOUND;
                  state_in      = S_IDLE;
               end else begin
                  pcnt_in  = pcnt_ff + SW'(1);
                  slot_in  = (step_sum >= {1'b0, size_ff}) ?
                             SW'(step_sum - {1'b0, size_ff}) : SW'(step_sum);
                  state_in = S_PROBE;
               end
            end else begin
               state_in = S_CMP_RD;
            end
         end

         S_CMP_RD: begin
            state_in = S_CMP;
         end

         // Character compare; a mismatch moves on to the next probe.
         S_CMP: begin
            if (nb_rd_ff != chr_rd_ff) begin
               if (last_probe) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (op_kind_ff == dhst_pkg::KIND_INSERT) ?
                                  dhst_pkg::ST_FULL : dhst_pkg::ST_NOT_FOUND;
                  state_in      = S_IDLE;
               end else begin
                  pcnt_in  = pcnt_ff + SW'(1);
                  slot_in  = (step_sum >= {1'b0, size_ff}) ?
                             SW'(step_sum - {1'b0, size_ff}) : SW'(step_sum);
                  state_in = S_PROBE;
               end
            end else if (NL_W'(j_ff) + NL_W'(1) == op_len_ff) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = dhst_pkg::INDEX_W'(slot_ff);
               if (op_kind_ff == dhst_pkg::KIND_INSERT) begin
                  rsp_status_in = dhst_pkg::ST_DUPLICATE;
               end else begin
                  rsp_status_in = dhst_pkg::ST_FOUND;
                  rsp_type_in   = meta_type;
               end
               state_in = S_IDLE;
            end else begin
               j_in     = j_ff + NI_W'(1);
               state_in = S_CMP_RD;
            end
         end

         S_COPY_RD: begin
            state_in = S_COPY_WR;
         end

         // Name buffer into the slot's character row.
         S_COPY_WR: begin
            chr_we = 1'b1;
            if (NL_W'(j_ff) + NL_W'(1) == op_len_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = dhst_pkg::ST_INSERTED;
               rsp_index_in  = dhst_pkg::INDEX_W'(slot_ff);
               state_in      = S_IDLE;
            end else begin
               j_in     = j_ff + NI_W'(1);
               state_in = S_COPY_RD;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_ff       <= dhst_pkg::SIZE_RESET;
         hash_ff      <= '0;
         len_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_en) csr_ff <= csr_write_data;
         hash_ff      <= hash_in;
         len_ff       <= len_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_len_ff     <= op_len_in;
      op_kind_ff    <= op_kind_in;
      op_type_ff    <= op_type_in;
      size_ff       <= size_in;
      key_ff        <= key_in;
      dcnt_ff       <= dcnt_in;
      rem1_ff       <= rem1_in;
      rem2_ff       <= rem2_in;
      slot_ff       <= slot_in;
      pcnt_ff       <= pcnt_in;
      j_ff          <= j_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_type_ff   <= rsp_type_in;
   end

   // Name buffer memory.
   always_ff @(posedge clock) begin
      if (nb_we) nb_mem[nb_waddr] <= req_name_char;
      nb_rd_ff <= nb_mem[j_ff];
   end

   // Slot type and length memory.
   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[slot_idx] <= {op_type_ff, op_len_ff};
      meta_rd_ff <= meta_mem[slot_idx];
   end

   // Slot character memory.
   always_ff @(posedge clock) begin
      if (chr_we) chr_mem[chr_addr] <= nb_rd_ff;
      chr_rd_ff <= chr_mem[chr_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_index_ff;
   assign rsp_found_type = rsp_type_ff;

endmodule

>>> rtl/dhst_checker.sv
// Port-level assertion checker for the double hash symbol table, and its bind.
// Depends on dhst_pkg and binds to double_hash_symbol_table.
module dhst_assert_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [dhst_pkg::KIND_W-1:0]    req_kind,
   input logic                           rsp_valid,
   input logic [dhst_pkg::STATUS_W-1:0]  rsp_status,
   input logic [dhst_pkg::INDEX_W-1:0]   rsp_slot_index,
   input logic [dhst_pkg::TYPE_W-1:0]    rsp_found_type
);

   // A clear transaction answers in the next cycle.
   a_clear_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == dhst_pkg::KIND_CLEAR |=>
         rsp_valid && rsp_status == dhst_pkg::ST_CLEARED)
      else $error("clear not answered");

   // Only a found entry carries a type.
   a_type_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dhst_pkg::ST_FOUND |-> rsp_found_type == '0)
      else $error("type on non-found result");

   // Slot index is zero unless a slot is named.
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dhst_pkg::ST_FOUND &&
      rsp_status != dhst_pkg::ST_INSERTED && rsp_status != dhst_pkg::ST_DUPLICATE
      |-> rsp_slot_index == '0)
      else $error("slot index on slotless result");

   // Reset leaves the block idle and silent.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind double_hash_symbol_table dhst_assert_checker u_dhst_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_slot_index (rsp_slot_index),
   .rsp_found_type (rsp_found_type)
);

>>> dv/dhst_checker.sv
// Checker for the double hash symbol table: watches the request, response and csr ports,
// keeps its own copy of the table and compares every response. Depends on dhst_pkg.
module dhst_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [dhst_pkg::KIND_W-1:0]    req_kind,
   input  logic [dhst_pkg::CHAR_W-1:0]    req_name_char,
   input  logic                           req_last_char,
   input  logic [dhst_pkg::TYPE_W-1:0]    req_var_type,
   input  logic                           rsp_valid,
   input  logic [dhst_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [dhst_pkg::INDEX_W-1:0]   rsp_slot_index,
   input  logic [dhst_pkg::TYPE_W-1:0]    rsp_found_type,
   input  logic                           csr_write_en,
   input  logic [dhst_pkg::CSR_W-1:0]     csr_write_data,
   output int                             fail_count,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dhst_pkg::*;

   localparam int DEPTH = 256;
   localparam int NBYTES = 50;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  slot;
      logic [TYPE_W-1:0]   ftype;
   } answer_t;

   answer_t              answer_q[$];
   logic [CSR_W-1:0]     size_reg;
   logic [HASH_W-1:0]    hash;
   logic [7:0]           name_buf[NBYTES];
   int                   name_len;
   logic                 valid_mark[DEPTH];
   logic [TYPE_W-1:0]    stored_type[DEPTH];
   int                   stored_len[DEPTH];
   logic [7:0]           stored_chars[DEPTH][NBYTES];

   initial fail_count = 0;
   assign pending = answer_q.size();

   task automatic report(input string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic bit same_name(input int slot);
      if (stored_len[slot] != name_len) return 0;
      for (int j = 0; j < name_len; j++)
         if (stored_chars[slot][j] != name_buf[j]) return 0;
      return 1;
   endfunction

   // Probe sequence for a finished name; returns the answer and updates the table.
   function automatic answer_t probe_table(input logic [KIND_W-1:0] kind,
                                           input logic [TYPE_W-1:0] vtype);
      int unsigned      size;
      logic [HASH_W-1:0] first, step, slot;
      answer_t          a;
      size = size_reg;
      if (size < SIZE_MIN) size = SIZE_MIN;
      if (size > DEPTH) size = DEPTH;
      first = hash % size;
      step = 1 + hash % (size - 3);
      for (int i = 0; i < size; i++) begin
         slot = (first + i * step) % size;
         if (!valid_mark[slot]) begin
            if (kind == KIND_INSERT) begin
               valid_mark[slot] = 1'b1;
               stored_type[slot] = vtype;
               stored_len[slot] = name_len;
               for (int j = 0; j < name_len; j++) stored_chars[slot][j] = name_buf[j];
               a = '{ST_INSERTED, slot[7:0], 2'd0};
            end else begin
               a = '{ST_NOT_FOUND, 8'd0, 2'd0};
            end
            return a;
         end
         if (same_name(slot)) begin
            if (kind == KIND_INSERT) a = '{ST_DUPLICATE, slot[7:0], 2'd0};
            else a = '{ST_FOUND, slot[7:0], stored_type[slot]};
            return a;
         end
      end
      a = '{(kind == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND, 8'd0, 2'd0};
      return a;
   endfunction

   always @(posedge clock) begin
      answer_t got, want;
      if (reset) begin
         answer_q.delete();
         size_reg = SIZE_RESET;
         hash = '0;
         name_len = 0;
         for (int s = 0; s < DEPTH; s++) valid_mark[s] = 1'b0;
      end else begin
         // Compare the response of this cycle with the oldest expectation.
         if (rsp_valid) begin
            got = '{rsp_status, rsp_slot_index, rsp_found_type};
            if (answer_q.size() == 0) begin
               report($sformatf("unexpected response status %0d", rsp_status));
            end else begin
               want = answer_q.pop_front();
               if (got.status != want.status)
                  report($sformatf("status %0d, want %0d", got.status, want.status));
               if (got.slot != want.slot)
                  report($sformatf("slot %0d, want %0d", got.slot, want.slot));
               if (got.ftype != want.ftype)
                  report($sformatf("type %0d, want %0d", got.ftype, want.ftype));
            end
         end
         if (csr_write_en) size_reg = csr_write_data;
         // Predict the outcome of an accepted transaction.
         if (start && !busy) begin
            if (req_kind == KIND_CLEAR) begin
               for (int s = 0; s < DEPTH; s++) valid_mark[s] = 1'b0;
               hash = '0;
               name_len = 0;
               answer_q.push_back('{ST_CLEARED, 8'd0, 2'd0});
            end else if (req_kind == KIND_INSERT || req_kind == KIND_LOOKUP) begin
               hash = hash * 31 + req_name_char;
               if (name_len < NBYTES - 1) name_buf[name_len] = {1'b0, req_name_char};
               if (name_len < NBYTES) name_len++;
               if (req_last_char) begin
                  if (name_len >= NBYTES)
                     answer_q.push_back('{ST_TOO_LONG, 8'd0, 2'd0});
                  else
                     answer_q.push_back(probe_table(req_kind, req_var_type));
                  hash = '0;
                  name_len = 0;
               end
            end
         end
      end
   end
endmodule

>>> dv/testbench.sv
// Top of the symbol table testbench: clock, reset, directed and random stimulus, verdict.
// Depends on dhst_pkg, double_hash_symbol_table and dhst_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dhst_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = KIND_INSERT;
   logic [CHAR_W-1:0]   req_name_char = '0;
   logic                req_last_char = 1'b0;
   logic [TYPE_W-1:0]   req_var_type = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0]  rsp_slot_index;
   logic [TYPE_W-1:0]   rsp_found_type;
   logic                csr_write_en = 1'b0;
   logic [CSR_W-1:0]    csr_write_data = '0;
   int                  fail_count;
   int                  pending;
   bit                  idle_on = 1'b1;
   int                  sent = 0;

   // Pool of names used by the directed and random parts so that repeats hit stored entries.
   logic [CHAR_W-1:0]   pool_chars[16][56];
   int                  pool_len[16];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   double_hash_symbol_table uut (.*);

   dhst_checker chk (.*);

   initial begin
      #50ms;
      $display("tb: failure");
      $finish;
   end

   // One transaction: optional idle burst, then hold start until the block takes it.
   task automatic send(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                       input logic last, input logic [TYPE_W-1:0] vtype);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_name_char <= ch;
      req_last_char <= last;
      req_var_type <= vtype;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   // Send a pool name with the given final kind; earlier characters carry random kinds.
   task automatic send_name(input int p, input logic [KIND_W-1:0] kind,
                            input logic [TYPE_W-1:0] vtype);
      for (int j = 0; j < pool_len[p]; j++)
         send((j == pool_len[p] - 1) ? kind : KIND_W'($urandom_range(0, 1)),
              pool_chars[p][j], j == pool_len[p] - 1, vtype);
   endtask

   task automatic fill_pool(input int p, input int len);
      pool_len[p] = len;
      for (int j = 0; j < len; j++) pool_chars[p][j] = CHAR_W'($urandom_range(0, 127));
   endtask

   // Let every expected transaction drain and the block fall idle.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (busy || pending != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_W-1:0] v);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      logic [CSR_W-1:0] sizes[10];
      int p;
      sizes = '{9'd5, 9'd7, 9'd0, 9'd13, 9'd511, 9'd11, 9'd256, 9'd3, 9'd31, 9'd251};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset size.
      fill_pool(0, 1); pool_chars[0][0] = 7'd127;
      fill_pool(1, 3); pool_chars[1][0] = 7'd0;
      fill_pool(2, 49);
      fill_pool(3, 50);
      send_name(0, KIND_INSERT, 2'd3);
      send_name(0, KIND_INSERT, 2'd1);
      send_name(0, KIND_LOOKUP, 2'd0);
      send_name(1, KIND_LOOKUP, 2'd0);
      send_name(1, KIND_INSERT, 2'd2);
      send_name(1, KIND_LOOKUP, 2'd0);
      send(KIND_LOOKUP, 7'd5, 1'b0, 2'd0);
      send(KIND_CLEAR, 7'd0, 1'b0, 2'd0);
      send(2'd3, 7'd99, 1'b1, 2'd3);
      send_name(0, KIND_LOOKUP, 2'd0);
      send_name(2, KIND_INSERT, 2'd1);
      send_name(2, KIND_LOOKUP, 2'd0);
      send_name(3, KIND_INSERT, 2'd0);
      send(KIND_CLEAR, 7'd127, 1'b1, 2'd3);
      send_name(2, KIND_LOOKUP, 2'd0);

      // Random phases, one per table size; the last runs without idling.
      foreach (sizes[k]) begin
         write_size(sizes[k]);
         if (k == 9) idle_on = 1'b0;
         for (int q = 0; q < 16; q++)
            fill_pool(q, ($urandom_range(0, 19) == 0) ? $urandom_range(45, 55)
                                                      : $urandom_range(1, 5));
         repeat (26) begin
            p = $urandom_range(0, 15);
            case ($urandom_range(0, 19))
               0: send(KIND_CLEAR, CHAR_W'($urandom), 1'($urandom), TYPE_W'($urandom));
               1: send(2'd3, CHAR_W'($urandom), 1'($urandom), TYPE_W'($urandom));
               2: send(KIND_W'($urandom_range(0, 1)), CHAR_W'($urandom), 1'($urandom),
                       TYPE_W'($urandom));
               default: send_name(p, KIND_W'($urandom_range(0, 1)), TYPE_W'($urandom));
            endcase
         end
      end

      // Final wait, then the verdict.
      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
